@@ src/uad_pkg.sv @@
// Shared types and constants of the unordered array dictionary.
`timescale 1ns / 1ps
`default_nettype none
package uad_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_BYTES = 10;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam logic [63:0] LOW_MASK  = (VALUE_BYTES >= 8) ? {64{1'b1}}
                                      : ((64'd1 << (8 * VALUE_BYTES)) - 64'd1);
    localparam logic [15:0] HIGH_MASK = (VALUE_BYTES >= 10) ? 16'hFFFF
                                      : ((VALUE_BYTES == 9) ? 16'h00FF : 16'h0000);

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] key;
        logic [63:0] value_low;
        logic [15:0] value_high;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] found_key;
        logic [63:0] found_value_low;
        logic [15:0] found_value_high;
        logic [4:0]  entry_total;
    } t_out_word;

    typedef struct packed {
        logic [15:0] key;
        logic [63:0] value_low;
        logic [15:0] value_high;
    } t_entry;

endpackage
`default_nettype wire

@@ src/unordered_array_dictionary_top.sv @@
// Top level of the unordered array dictionary with linear search.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Command channel: drive the command word on i_in and raise start; the
//   word is taken at a rising edge where start is high and busy is low.
//   busy stays high until the result is out; hold start or drop it freely.
//   Result channel: o_done pulses for one cycle with the result word on
//   o_out. The receiver cannot stall, so take the word in that cycle.
// Operation:
//   The entries live in one RAM with registered read. The scan takes
//   each entry through a read (S_SCAN_RD), then a compare (S_SCAN_CHK),
//   and stops at the first matching key (a hit) or at the end of the
//   stored entries (a miss). A remove that hits then shifts the later
//   entries down one place, one read and one write each. busy is low
//   while o_done is high, so the next word can be taken at the edge
//   that ends the o_done cycle.
// Reset: i_rst_n (synchronous, active low) empties the table at once; the
//   RAM contents are not cleared, since entries at or above the count are
//   never read. No clearing pass is needed.
module unordered_array_dictionary_top
    import uad_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_word  i_in,
    output logic           o_done,
    output t_out_word      o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR
    } t_state;

    t_state          r_state;
    t_in_word        r_cmd;       // captured command, value masked
    logic [CNT_W-1:0] r_count;    // stored entries
    logic [CNT_W-1:0] r_idx;      // scan / shift position
    logic            r_hit;
    t_entry          r_ent;       // entry found by the scan
    logic            r_done;
    t_out_word       r_out;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    t_entry           new_ent;
    logic [CNT_W:0]   idx_plus2;
    logic             sh_last;

    t_out_word        n_out;
    logic [CNT_W-1:0] n_count;
    logic             n_shift;
    logic             n_done;

    assign new_ent   = '{key: r_cmd.key, value_low: r_cmd.value_low,
                         value_high: r_cmd.value_high};
    assign idx_plus2 = {1'b0, r_idx} + (CNT_W+1)'(2);
    // Last move of the shift: the final entry has come down.
    assign sh_last   = (idx_plus2 >= {1'b0, r_count});

    // Memory port control: scan and shift reads, insert and shift writes.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = rd_data;
        case (r_state)
            S_SCAN_RD: begin
                rd_en = (r_idx != r_count);
            end
            S_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx[IDX_W-1:0] + IDX_W'(1);
            end
            S_SH_WR: begin
                wr_en = 1'b1;
            end
            S_DECIDE: begin
                // Append only when the key is absent and a slot is free.
                wr_en   = (r_cmd.operation == OP_INSERT) && !r_hit &&
                          (r_count != CNT_W'(CAPACITY));
                wr_addr = r_count[IDX_W-1:0];
                wr_data = new_ent;
            end
            default: begin
            end
        endcase
    end

    // Result word and table size once the scan has settled.
    always_comb begin
        n_out             = '0;
        n_out.status      = ST_NOT_FOUND;
        n_out.entry_total = 5'(r_count);
        n_count           = r_count;
        n_shift           = 1'b0;
        case (r_cmd.operation)
            OP_FIND: begin
                if (r_hit) begin
                    n_out.status           = ST_OK;
                    n_out.found_key        = r_ent.key;
                    n_out.found_value_low  = r_ent.value_low;
                    n_out.found_value_high = r_ent.value_high;
                end
            end
            OP_INSERT: begin
                if (r_hit) begin
                    n_out.status = ST_DUPLICATE;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count                = r_count + CNT_W'(1);
                    n_out.entry_total      = 5'(r_count + CNT_W'(1));
                    n_out.status           = ST_OK;
                    n_out.found_key        = new_ent.key;
                    n_out.found_value_low  = new_ent.value_low;
                    n_out.found_value_high = new_ent.value_high;
                end
            end
            OP_REMOVE: begin
                if (r_hit) begin
                    n_out.status           = ST_OK;
                    n_out.found_key        = r_ent.key;
                    n_out.found_value_low  = r_ent.value_low;
                    n_out.found_value_high = r_ent.value_high;
                    if ({1'b0, r_idx} + (CNT_W+1)'(1) < {1'b0, r_count}) begin
                        // Hold the result until the shift is over.
                        n_shift = 1'b1;
                    end else begin
                        n_count           = r_count - CNT_W'(1);
                        n_out.entry_total = 5'(r_count - CNT_W'(1));
                    end
                end
            end
            default: begin
            end
        endcase
        n_done = ((r_state == S_DECIDE) && !n_shift) ||
                 ((r_state == S_SH_WR) && sh_last);
    end

    uad_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= n_done;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= '{operation: i_in.operation, key: i_in.key,
                                     value_low: i_in.value_low & LOW_MASK,
                                     value_high: i_in.value_high & HIGH_MASK};
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    // Stop at the end of the stored entries: key absent.
                    r_state <= (r_idx == r_count) ? S_DECIDE : S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (rd_data.key == r_cmd.key) begin
                        r_hit   <= 1'b1;
                        r_ent   <= rd_data;
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DECIDE: begin
                    r_out   <= n_out;
                    r_count <= n_count;
                    r_state <= n_shift ? S_SH_RD : S_IDLE;
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    // Advance until the last entry has moved down.
                    if (sh_last) begin
                        r_count           <= r_count - CNT_W'(1);
                        r_out.entry_total <= 5'(r_count - CNT_W'(1));
                        r_state           <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_SH_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

endmodule
`default_nettype wire

@@ src/uad_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module uad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ src/uad_check.sv @@
// Port-level checker for the dictionary top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module uad_check
    import uad_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_done,
    input wire t_out_word o_out
);

    // A word taken in starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // A result shows only once the block is free again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Every finished word gives its result as busy drops.
    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // Failed operations return an empty entry.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_out.status != ST_OK) |->
            (o_out.found_key == 16'd0) && (o_out.found_value_low == 64'd0))
        else $error("entry returned with a failing status");

    // Count never goes beyond the capacity.
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.entry_total <= 5'(CAPACITY)))
        else $error("entry total above capacity");

endmodule

bind unordered_array_dictionary_top uad_check u_uad_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_out   (o_out)
);
`default_nettype wire

@@ tb/tb_unordered_array_dictionary_top.sv @@
// Self-checking testbench of the unordered array dictionary (directed and random commands).
`timescale 1ns / 1ps
module tb_unordered_array_dictionary_top;
    import uad_pkg::*;

    // Operation code that the block must treat as a no-op miss.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int N_RANDOM     = 875;
    localparam int MAX_GAP      = 11;
    localparam int POOL_SIZE    = 24;
    // Worst legal quiet stretch is a sender gap plus one full scan;
    // the limit allows many times that.
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  i_in    = '0;
    logic      busy;
    logic      o_done;
    t_out_word o_out;

    unordered_array_dictionary_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Behavioral dictionary: arrival-ordered entries with unique keys.
    // ------------------------------------------------------------------
    t_entry    dict_entry [CAPACITY];
    int        dict_count = 0;

    t_in_word  command_queue [$];     // words still to be sent, front is on i_in
    t_out_word predicted_replies [$]; // replies owed by the block, oldest first

    int        mismatches   = 0;
    int        replies_seen = 0;
    int        gap_left     = 0;
    int        stretch_left = 0;
    bit        no_idle      = 1'b0;
    int        stall_cycles = 0;

    // Apply one command to the dictionary and return the reply it owes.
    function automatic t_out_word dict_apply(t_in_word cmd);
        t_out_word reply;
        t_entry    ent;
        int        pos;
        reply          = '0;
        reply.status   = ST_NOT_FOUND;
        ent.key        = cmd.key;
        ent.value_low  = cmd.value_low & LOW_MASK;
        ent.value_high = cmd.value_high & HIGH_MASK;
        // Scan from the newest down so that pos ends on the oldest match.
        pos = dict_count;
        for (int i = dict_count - 1; i >= 0; i--) begin
            if (dict_entry[i].key == cmd.key)
                pos = i;
        end
        case (cmd.operation)
            OP_FIND: begin
                if (pos < dict_count) begin
                    reply.status           = ST_OK;
                    reply.found_key        = dict_entry[pos].key;
                    reply.found_value_low  = dict_entry[pos].value_low;
                    reply.found_value_high = dict_entry[pos].value_high;
                end
            end
            OP_INSERT: begin
                if (pos < dict_count) begin
                    reply.status = ST_DUPLICATE;
                end else if (dict_count >= CAPACITY) begin
                    reply.status = ST_FULL;
                end else begin
                    dict_entry[dict_count] = ent;
                    dict_count++;
                    reply.status           = ST_OK;
                    reply.found_key        = ent.key;
                    reply.found_value_low  = ent.value_low;
                    reply.found_value_high = ent.value_high;
                end
            end
            OP_REMOVE: begin
                if (pos < dict_count) begin
                    reply.status           = ST_OK;
                    reply.found_key        = dict_entry[pos].key;
                    reply.found_value_low  = dict_entry[pos].value_low;
                    reply.found_value_high = dict_entry[pos].value_high;
                    // Close the hole, keeping arrival order of the rest.
                    for (int j = pos; j < dict_count - 1; j++)
                        dict_entry[j] = dict_entry[j + 1];
                    dict_count--;
                end
            end
            default: ;
        endcase
        reply.entry_total = 5'(dict_count);
        return reply;
    endfunction

    // Sender idle time before the next word: random gaps, with stretches of
    // back-to-back words mixed in.
    function automatic int draw_gap();
        if (stretch_left == 0) begin
            no_idle      = ($urandom_range(0, 3) == 0);
            stretch_left = $urandom_range(10, 40);
        end
        stretch_left--;
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic add_command(logic [1:0] op, logic [15:0] key,
                               logic [63:0] lo, logic [15:0] hi);
        t_in_word cmd;
        cmd.operation  = op;
        cmd.key        = key;
        cmd.value_low  = lo;
        cmd.value_high = hi;
        command_queue.push_back(cmd);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the front word, hold it while busy, drop start for
    // the drawn gap after each accept.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                // Word taken at this edge: predict its reply, then retire it.
                predicted_replies.push_back(dict_apply(i_in));
                void'(command_queue.pop_front());
                gap_left = draw_gap();
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    start <= 1'b0;
                    gap_left--;
                end else if (command_queue.size() > 0) begin
                    i_in  <= command_queue[0];
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every o_done pulse is one reply; compare it field by field
    // with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_replies
        t_out_word want;
        if (i_rst_n && o_done) begin
            replies_seen++;
            if (predicted_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: reply %0d arrived with nothing outstanding: %p",
                             $time, replies_seen, o_out);
            end else begin
                want = predicted_replies.pop_front();
                if (o_out.status !== want.status
                        || o_out.found_key !== want.found_key
                        || o_out.found_value_low !== want.found_value_low
                        || o_out.found_value_high !== want.found_value_high
                        || o_out.entry_total !== want.entry_total) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: reply %0d mismatch", $time, replies_seen);
                        $display("  expected st=%0d key=%h lo=%h hi=%h total=%0d",
                                 want.status, want.found_key, want.found_value_low,
                                 want.found_value_high, want.entry_total);
                        $display("  actual   st=%0d key=%h lo=%h hi=%h total=%0d",
                                 o_out.status, o_out.found_key, o_out.found_value_low,
                                 o_out.found_value_high, o_out.entry_total);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] key_pool [POOL_SIZE];
        logic [15:0] key;
        logic [63:0] lo;
        logic [15:0] hi;
        logic [1:0]  op;
        int          insert_pct;
        int          roll;

        // Directed: empty-table misses, unused opcode, extreme keys and values.
        add_command(OP_FIND,   16'h0000, '0, '0);
        add_command(OP_REMOVE, 16'hFFFF, '0, '0);
        add_command(OP_UNUSED, 16'hA5A5, {$urandom, $urandom}, 16'($urandom));
        add_command(OP_INSERT, 16'h0000, '0, '0);
        add_command(OP_INSERT, 16'hFFFF, '1, '1);
        // Insert of a present key must report a duplicate and change nothing.
        add_command(OP_INSERT, 16'h0000, '1, '1);
        add_command(OP_FIND,   16'hFFFF, '0, '0);
        // Fill the table to capacity, then overflow it.
        for (int k = 1; k <= CAPACITY - 2; k++)
            add_command(OP_INSERT, 16'(k), {$urandom, $urandom}, 16'($urandom));
        add_command(OP_INSERT, 16'h1234, {$urandom, $urandom}, 16'($urandom));
        add_command(OP_FIND,   16'(CAPACITY - 2), '0, '0);
        // Remove the oldest entry (longest shift) and one from the middle.
        add_command(OP_REMOVE, 16'h0000, '0, '0);
        add_command(OP_REMOVE, 16'h0007, '0, '0);

        // Random: a small key pool keeps hits frequent; the insert share
        // swings by phase so the table fills up and drains repeatedly.
        foreach (key_pool[i])
            key_pool[i] = 16'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        insert_pct = 50;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 60 == 0)
                insert_pct = $urandom_range(15, 75);
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_UNUSED;
            else if (roll < 3 + insert_pct)
                op = OP_INSERT;
            else if (roll < 3 + insert_pct + (97 - insert_pct) / 2)
                op = OP_FIND;
            else
                op = OP_REMOVE;
            if ($urandom_range(0, 99) < 85)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                key = 16'($urandom);
            // Refresh the pool now and then so new keys keep appearing.
            if ($urandom_range(0, 49) == 0)
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);
            case ($urandom_range(0, 9))
                0: begin
                    lo = '0;
                    hi = '0;
                end
                1: begin
                    lo = '1;
                    hi = '1;
                end
                default: begin
                    lo = {$urandom, $urandom};
                    hi = 16'($urandom);
                end
            endcase
            add_command(op, key, lo, hi);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample away from the active edge so queue updates have settled.
        while (command_queue.size() > 0 || predicted_replies.size() > 0)
            @(negedge i_clk);
        // Let any stray reply show up before judging.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && predicted_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/uad_pkg.sv
src/uad_ram.sv
src/unordered_array_dictionary_top.sv
src/uad_check.sv
tb/tb_unordered_array_dictionary_top.sv
